>>> rtl/core/rfa_pkg.sv
// shared types and codes for the rational fraction alu
`default_nettype none

package rfa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [1:0] t_func;
    localparam t_func F_ADD = 2'd0;
    localparam t_func F_SUB = 2'd1;
    localparam t_func F_MUL = 2'd2;
    localparam t_func F_DIV = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind K_PASS = 2'd0;
    localparam t_kind K_MUL  = 2'd1;
    localparam t_kind K_ADD  = 2'd2;
    localparam t_kind K_SUB  = 2'd3;

    typedef struct packed {
        t_kind kind;
        logic  err;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

`default_nettype wire

>>> rtl/core/rfa_front.sv
// input stage: accepts an item and sorts it into a job kind
`default_nettype none

module rfa_front #(
    parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire rfa_pkg::t_func               i_func,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_num,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_den,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_num,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_den,
    output logic                              o_valid,
    output rfa_pkg::t_ctl                     o_ctl,
    output logic [DATA_WIDTH-1:0]             o_an,
    output logic [DATA_WIDTH-1:0]             o_ad,
    output logic [DATA_WIDTH-1:0]             o_bn,
    output logic [DATA_WIDTH-1:0]             o_bd,
    input  wire logic                         i_take
);
    import rfa_pkg::*;

    logic                  r_valid;
    t_ctl                  r_ctl, n_ctl;
    logic [DATA_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic [DATA_WIDTH-1:0] n_an, n_ad, n_bn, n_bd;
    logic                  accept;

    assign full   = r_valid && !i_take;
    assign accept = push && !full;

    always_comb begin
        n_ctl.err  = 1'b0;
        n_ctl.kind = K_PASS;
        n_an = i_a_num;
        n_ad = i_a_den;
        n_bn = i_b_num;
        n_bd = i_b_den;
        unique case (i_func)
            F_ADD, F_SUB: begin
                if (i_a_den == i_b_den) begin
                    n_ctl.kind = K_PASS;
                    n_an = (i_func == F_ADD) ? i_a_num + i_b_num : i_a_num - i_b_num;
                end else begin
                    n_ctl.kind = (i_func == F_ADD) ? K_ADD : K_SUB;
                end
            end
            F_MUL: n_ctl.kind = K_MUL;
            F_DIV: begin
                n_ctl.kind = K_MUL;
                n_bn = i_b_den;
                n_bd = i_b_num;
            end
            default: n_ctl.kind = K_PASS;
        endcase
        if (i_a_den == '0 || i_b_den == '0) begin
            n_ctl.kind = K_PASS;
            n_ctl.err  = 1'b1;
            n_an = '0;
            n_ad = DATA_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctl <= n_ctl;
            r_an  <= n_an;
            r_ad  <= n_ad;
            r_bn  <= n_bn;
            r_bd  <= n_bd;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_an    = r_an;
    assign o_ad    = r_ad;
    assign o_bn    = r_bn;
    assign o_bd    = r_bd;

endmodule

`default_nettype wire

>>> rtl/core/rfa_fifo.sv
// short job queue between front and back
`default_nettype none

module rfa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rfa_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic             wr, rd;

    assign o_full  = r_cnt == (PW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rfa_arith.sv
// shared iterative unit: wrapping multiply or truncating signed divide, one bit a cycle
`default_nettype none

module rfa_arith #(
    parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_mul,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    output logic                       o_done,
    output logic [DATA_WIDTH-1:0]      o_quo,
    output logic [DATA_WIDTH-1:0]      o_rem
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          r_busy, r_done, r_mul, r_qneg, r_rneg;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_x, r_y, r_acc, r_q, r_r;
    logic [W-1:0]  n_x, n_y, n_acc, mag_a, mag_b;
    logic [W:0]    sh, diff;
    logic          last;

    assign mag_a = i_a[W-1] ? -i_a : i_a;
    assign mag_b = i_b[W-1] ? -i_b : i_b;
    assign last  = r_cnt == CW'(1);
    assign sh    = {r_acc, r_x[W-1]};
    assign diff  = sh - {1'b0, r_y};

    always_comb begin
        if (r_mul) begin
            n_acc = r_acc + (r_y[0] ? r_x : '0);
            n_x   = r_x << 1;
            n_y   = r_y >> 1;
        end else begin
            n_y = r_y;
            if (!diff[W]) begin
                n_acc = diff[W-1:0];
                n_x   = {r_x[W-2:0], 1'b1};
            end else begin
                n_acc = sh[W-1:0];
                n_x   = {r_x[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (!i_mul && i_b == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul  <= i_mul;
            r_acc  <= '0;
            r_qneg <= i_a[W-1] ^ i_b[W-1];
            r_rneg <= i_a[W-1];
            if (i_mul) begin
                r_x <= i_a;
                r_y <= i_b;
            end else begin
                r_x <= mag_a;
                r_y <= mag_b;
            end
            if (!i_mul && i_b == '0) begin
                r_q <= '0;
                r_r <= i_a;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= n_x;
            r_y   <= n_y;
            if (last) begin
                if (r_mul) begin
                    r_q <= n_acc;
                end else begin
                    r_q <= r_qneg ? -n_x : n_x;
                    r_r <= r_rneg ? -n_acc : n_acc;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

endmodule

`default_nettype wire

>>> rtl/core/rfa_back.sv
// job sequencer: gcd, lcm, scaling and product steps on the shared unit, plus result register
`default_nettype none

module rfa_back #(
    parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire rfa_pkg::t_ctl          i_ctl,
    input  wire logic [DATA_WIDTH-1:0]  i_an,
    input  wire logic [DATA_WIDTH-1:0]  i_ad,
    input  wire logic [DATA_WIDTH-1:0]  i_bn,
    input  wire logic [DATA_WIDTH-1:0]  i_bd,
    output logic                        o_take,
    output logic                        empty,
    input  wire logic                   pop,
    output logic signed [DATA_WIDTH-1:0] o_res_num,
    output logic signed [DATA_WIDTH-1:0] o_res_den,
    output logic                        o_zero_den_error
);
    import rfa_pkg::*;

    localparam int W = DATA_WIDTH;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_GCD1 = 4'd1;
    localparam logic [3:0] ST_DAN  = 4'd2;
    localparam logic [3:0] ST_DAD  = 4'd3;
    localparam logic [3:0] ST_GCD2 = 4'd4;
    localparam logic [3:0] ST_MP   = 4'd5;
    localparam logic [3:0] ST_DL   = 4'd6;
    localparam logic [3:0] ST_DKA  = 4'd7;
    localparam logic [3:0] ST_MTA  = 4'd8;
    localparam logic [3:0] ST_DKB  = 4'd9;
    localparam logic [3:0] ST_MTB  = 4'd10;
    localparam logic [3:0] ST_FIN  = 4'd11;
    localparam logic [3:0] ST_MD   = 4'd12;
    localparam logic [3:0] ST_MN   = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    logic [3:0]   r_state;
    logic         r_wait, r_err, r_ovalid, r_oerr;
    t_kind        r_kind;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd, r_ga, r_gb, r_p, r_k, r_ta, r_tb;
    logic [W-1:0] r_rn, r_rd, r_onum, r_oden;

    logic         u_start, u_mul, u_done, gcd_end, unit_state, load_out;
    logic [W-1:0] u_a, u_b, u_quo, u_rem;

    assign gcd_end  = (r_state == ST_GCD1 || r_state == ST_GCD2) && r_gb == '0;
    assign u_start  = unit_state && !r_wait && !gcd_end;
    assign o_take   = r_state == ST_IDLE && i_valid;
    assign load_out = r_state == ST_OUT && (!r_ovalid || pop);

    always_comb begin
        unit_state = 1'b1;
        u_mul = 1'b0;
        u_a   = r_ga;
        u_b   = r_gb;
        unique case (r_state)
            ST_GCD1, ST_GCD2: begin
                u_a = r_ga;
                u_b = r_gb;
            end
            ST_DAN: begin
                u_a = r_an;
                u_b = r_ga;
            end
            ST_DAD: begin
                u_a = r_ad;
                u_b = r_ga;
            end
            ST_MP, ST_MD: begin
                u_mul = 1'b1;
                u_a   = r_ad;
                u_b   = r_bd;
            end
            ST_DL: begin
                u_a = r_p;
                u_b = r_ga;
            end
            ST_DKA: begin
                u_a = r_p;
                u_b = r_ad;
            end
            ST_MTA: begin
                u_mul = 1'b1;
                u_a   = r_an;
                u_b   = r_k;
            end
            ST_DKB: begin
                u_a = r_p;
                u_b = r_bd;
            end
            ST_MTB: begin
                u_mul = 1'b1;
                u_a   = r_bn;
                u_b   = r_k;
            end
            ST_MN: begin
                u_mul = 1'b1;
                u_a   = r_an;
                u_b   = r_bn;
            end
            default: unit_state = 1'b0;
        endcase
    end

    rfa_arith #(
        .DATA_WIDTH(W)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_mul   (u_mul),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_done  (u_done),
        .o_quo   (u_quo),
        .o_rem   (u_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
            if (u_start) begin
                r_wait <= 1'b1;
            end else if (u_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        unique case (i_ctl.kind)
                            K_PASS:  r_state <= ST_OUT;
                            K_MUL:   r_state <= ST_MD;
                            K_ADD:   r_state <= ST_GCD1;
                            K_SUB:   r_state <= ST_GCD2;
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                ST_GCD1: if (gcd_end) r_state <= ST_DAN;
                ST_GCD2: if (gcd_end) r_state <= ST_MP;
                ST_DAN:  if (u_done) r_state <= ST_DAD;
                ST_DAD:  if (u_done) r_state <= ST_GCD2;
                ST_MP:   if (u_done) r_state <= ST_DL;
                ST_DL:   if (u_done) r_state <= ST_DKA;
                ST_DKA:  if (u_done) r_state <= ST_MTA;
                ST_MTA:  if (u_done) r_state <= ST_DKB;
                ST_DKB:  if (u_done) r_state <= ST_MTB;
                ST_MTB:  if (u_done) r_state <= ST_FIN;
                ST_FIN:  r_state <= ST_OUT;
                ST_MD:   if (u_done) r_state <= ST_MN;
                ST_MN:   if (u_done) r_state <= ST_OUT;
                ST_OUT:  if (load_out) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_kind <= i_ctl.kind;
                r_err  <= i_ctl.err;
                r_an   <= i_an;
                r_ad   <= i_ad;
                r_bn   <= i_bn;
                r_bd   <= i_bd;
                r_rn   <= i_an;
                r_rd   <= i_ad;
                if (i_ctl.kind == K_ADD) begin
                    r_ga <= i_an;
                    r_gb <= i_ad;
                end else begin
                    r_ga <= i_ad;
                    r_gb <= i_bd;
                end
            end
            ST_GCD1, ST_GCD2: begin
                if (u_done) begin
                    r_ga <= r_gb;
                    r_gb <= u_rem;
                end
            end
            ST_DAN: if (u_done) r_an <= u_quo;
            ST_DAD: begin
                if (u_done) begin
                    r_ad <= u_quo;
                    r_ga <= u_quo;
                    r_gb <= r_bd;
                end
            end
            ST_MP:  if (u_done) r_p <= u_quo;
            ST_DL:  if (u_done) r_p <= u_quo;
            ST_DKA: if (u_done) r_k <= u_quo;
            ST_MTA: if (u_done) r_ta <= u_quo;
            ST_DKB: if (u_done) r_k <= u_quo;
            ST_MTB: if (u_done) r_tb <= u_quo;
            ST_FIN: begin
                r_rn <= (r_kind == K_ADD) ? r_ta + r_tb : r_ta - r_tb;
                r_rd <= r_p;
            end
            ST_MD:  if (u_done) r_rd <= u_quo;
            ST_MN:  if (u_done) r_rn <= u_quo;
            default: ;
        endcase
        if (load_out) begin
            r_onum <= r_rn;
            r_oden <= r_rd;
            r_oerr <= r_err;
        end
    end

    assign empty            = !r_ovalid;
    assign o_res_num        = r_onum;
    assign o_res_den        = r_oden;
    assign o_zero_den_error = r_oerr;

endmodule

`default_nettype wire

>>> rtl/core/rational_fraction_alu.sv
// rational fraction alu: front stage, job queue and iterative back end
// back end works one item at a time, running each step on the shared iterative unit
// multiply and divide items: 2 unit steps
// unequal-denominator add: 8 unit steps, subtract: 6, each plus its gcd remainder steps
// equal-denominator and zero-denominator items pass through without unit steps
// synchronous active-low reset empties the queue and the result register
`default_nettype none

module rational_fraction_alu #(
    parameter int DATA_WIDTH = rfa_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire rfa_pkg::t_func               i_func,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_num,
    input  wire logic signed [DATA_WIDTH-1:0] i_a_den,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_num,
    input  wire logic signed [DATA_WIDTH-1:0] i_b_den,
    output logic                              empty,
    input  wire logic                         pop,
    output logic signed [DATA_WIDTH-1:0]      o_res_num,
    output logic signed [DATA_WIDTH-1:0]      o_res_den,
    output logic                              o_zero_den_error
);
    import rfa_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int QW = CTL_W + 4 * W;

    logic          f_valid, q_full, q_empty, b_take;
    t_ctl          f_ctl, q_ctl;
    logic [W-1:0]  f_an, f_ad, f_bn, f_bd, q_an, q_ad, q_bn, q_bd;
    logic [QW-1:0] q_rdata;

    rfa_front #(
        .DATA_WIDTH(W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_func  (i_func),
        .i_a_num (i_a_num),
        .i_a_den (i_a_den),
        .i_b_num (i_b_num),
        .i_b_den (i_b_den),
        .o_valid (f_valid),
        .o_ctl   (f_ctl),
        .o_an    (f_an),
        .o_ad    (f_ad),
        .o_bn    (f_bn),
        .o_bd    (f_bd),
        .i_take  (!q_full)
    );

    rfa_fifo #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_wdata ({f_ctl, f_an, f_ad, f_bn, f_bd}),
        .o_full  (q_full),
        .i_rd    (b_take),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {q_ctl, q_an, q_ad, q_bn, q_bd} = q_rdata;

    rfa_back #(
        .DATA_WIDTH(W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!q_empty),
        .i_ctl            (q_ctl),
        .i_an             (q_an),
        .i_ad             (q_ad),
        .i_bn             (q_bn),
        .i_bd             (q_bd),
        .o_take           (b_take),
        .empty            (empty),
        .pop              (pop),
        .o_res_num        (o_res_num),
        .o_res_den        (o_res_den),
        .o_zero_den_error (o_zero_den_error)
    );

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_take |-> !q_empty)
        else $error("back end took a job from an empty queue");

    a_front_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && q_full) |-> full)
        else $error("input accepted while front stage is blocked");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_zero_den_error) |-> (o_res_num == '0 && o_res_den == W'(1)))
        else $error("zero denominator item did not give 0/1");

endmodule

`default_nettype wire

>>> sim/rational_fraction_alu_tb.sv
// testbench for the rational fraction alu: directed and random fraction items checked against a predictor
`timescale 1ns / 1ps

class fraction_scoreboard;
    typedef struct {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               err;
    } t_frac;

    t_frac pending[$];
    int    n_fail;

    function new();
        n_fail = 0;
    endfunction

    static function logic [31:0] mag(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    static function logic [31:0] quo(logic [31:0] a, logic [31:0] b);
        logic [31:0] q;
        if (b == 0) return 0;
        q = mag(a) / mag(b);
        if (a[31] != b[31]) q = -q;
        return q;
    endfunction

    static function logic [31:0] rem(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        if (b == 0) return a;
        r = mag(a) % mag(b);
        if (a[31]) r = -r;
        return r;
    endfunction

    static function logic [31:0] gcd(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        if (a == b) return a;
        while (b != 0) begin
            t = rem(a, b);
            a = b;
            b = t;
        end
        return a;
    endfunction

    function void note_item(rfa_pkg::t_func f, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        t_frac r;
        logic [31:0] g, l, ta, tb;
        r.err = 0;
        if (ad == 0 || bd == 0) begin
            r.num = 0; r.den = 1; r.err = 1;
        end else if (f == rfa_pkg::F_ADD || f == rfa_pkg::F_SUB) begin
            if (ad == bd) begin
                r.den = ad;
                r.num = (f == rfa_pkg::F_ADD) ? an + bn : an - bn;
            end else begin
                if (f == rfa_pkg::F_ADD) begin
                    g = gcd(an, ad);
                    an = quo(an, g);
                    ad = quo(ad, g);
                end
                l = quo(ad * bd, gcd(ad, bd));
                ta = an * quo(l, ad);
                tb = bn * quo(l, bd);
                r.den = l;
                r.num = (f == rfa_pkg::F_ADD) ? ta + tb : ta - tb;
            end
        end else if (f == rfa_pkg::F_MUL) begin
            r.den = ad * bd; r.num = an * bn;
        end else begin
            r.den = ad * bn; r.num = an * bd;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] num, logic [31:0] den, logic err);
        t_frac e;
        if (pending.size() == 0) begin
            $error("result with no item waiting");
            n_fail++;
            return;
        end
        e = pending.pop_front();
        if (num !== e.num) begin
            $error("res_num expected %0d actual %0d", e.num, $signed(num)); n_fail++;
        end
        if (den !== e.den) begin
            $error("res_den expected %0d actual %0d", e.den, $signed(den)); n_fail++;
        end
        if (err !== e.err) begin
            $error("zero_den_error expected %0b actual %0b", e.err, err); n_fail++;
        end
    endfunction
endclass

module rational_fraction_alu_tb;
    import rfa_pkg::*;

    localparam int N_RAND = 800;
    localparam int LIMIT  = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    t_func              i_func;
    logic signed [31:0] i_a_num;
    logic signed [31:0] i_a_den;
    logic signed [31:0] i_b_num;
    logic signed [31:0] i_b_den;
    logic               empty;
    logic               pop;
    logic signed [31:0] o_res_num;
    logic signed [31:0] o_res_den;
    logic               o_zero_den_error;

    fraction_scoreboard sb = new();
    bit  feed_done;
    bit  calm;
    bit  hold_long;
    int  idle_cycles;

    rational_fraction_alu i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_func(i_func),
        .i_a_num(i_a_num), .i_a_den(i_a_den), .i_b_num(i_b_num), .i_b_den(i_b_den),
        .empty(empty), .pop(pop), .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_zero_den_error(o_zero_den_error)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return -1;
            4: return 1;
            5, 6: return $urandom_range(0, 40) - 20;
            7: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(t_func f, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        push    <= 1;
        i_func  <= f;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (full);
        sb.note_item(f, an, ad, bn, bd);
    endtask

    task automatic send_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] d;
        push = 0; pop = 0; i_func = F_ADD;
        i_a_num = 0; i_a_den = 1; i_b_num = 0; i_b_den = 1;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed items
        send_item(F_ADD, 1, 2, 1, 3);
        send_item(F_SUB, 1, 2, 1, 3);
        send_item(F_MUL, 3, 4, -5, 7);
        send_item(F_DIV, 3, 4, -5, 7);
        send_item(F_ADD, 5, 9, 7, 9);
        send_item(F_SUB, 5, 9, 7, 9);
        send_item(F_ADD, 1, 0, 1, 2);
        send_item(F_DIV, 1, 2, 3, 0);
        send_item(F_DIV, 1, 2, 0, 5);
        send_item(F_ADD, 32'h8000_0000, -1, 1, 3);
        send_item(F_SUB, 32'h8000_0000, -1, 1, 3);
        send_item(F_ADD, -6, 4, 1, -6);
        send_item(F_SUB, 4, -6, -3, 9);
        send_item(F_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(F_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_item(F_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0001);
        send_item(F_SUB, 0, 7, 0, 5);
        send_item(F_ADD, 0, 0, 0, 0);
        for (int k = 0; k < N_RAND; k++) begin
            if (k > N_RAND - 100) calm = 1;
            if (k == 100) hold_long = 1;
            d = pick_value();
            if ($urandom_range(0, 4) == 0)
                send_item(t_func'($urandom_range(0, 3)), pick_value(), d, pick_value(), d);
            else
                send_item(t_func'($urandom_range(0, 3)), pick_value(), pick_value(),
                          pick_value(), pick_value());
            send_gap();
        end
        push <= 0;
        feed_done = 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result(o_res_num, o_res_den, o_zero_den_error);
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                hold_long = 0;
                pop <= 0;
                repeat (400) @(posedge i_clk);
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                pop <= 0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                pop <= 1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        fork
            begin
                wait (feed_done && sb.pending.size() == 0);
                repeat (300) @(posedge i_clk);
                if (sb.n_fail == 0)
                    $display("All tests passed");
                else
                    $display("Some tests failed");
                $finish;
            end
            begin
                wait (idle_cycles >= LIMIT);
                $display("Some tests failed");
                $finish;
            end
        join
    end
endmodule

>>> rational_fraction_alu.f
rtl/core/rfa_pkg.sv
rtl/core/rfa_front.sv
rtl/core/rfa_fifo.sv
rtl/core/rfa_arith.sv
rtl/core/rfa_back.sv
rtl/core/rational_fraction_alu.sv
sim/rational_fraction_alu_tb.sv
